[design/pwq_pkg.sv]
// pwq_pkg: shared operation codes, state encoding and cell control bundle
// for the pid wait queue. No dependencies.

package pwq_pkg;

  // operation codes on in_mode
  localparam logic [1:0] MODE_ENQUEUE    = 2'd0;
  localparam logic [1:0] MODE_DEQUEUE    = 2'd1;
  localparam logic [1:0] MODE_HAS        = 2'd2;
  localparam logic [1:0] MODE_REMOVE_ALL = 2'd3;

  // controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_COMPACT = 2'b10
  } pwq_state_t;

  // control broadcast from the controller to every cell
  typedef struct packed {
    logic load;       // write key into the tail cell
    logic shift_all;  // every cell takes its upper neighbor (dequeue)
    logic compact;    // cells at or above the lowest mark take their upper neighbor
    logic mark_en;    // capture key matches into the mark bits
  } pwq_ctrl_t;

endpackage

[design/pwq_cell.sv]
// pwq_cell: one slot of the queue chain, holding a pid and a delete mark.
// Depends on pwq_pkg for the control bundle.

module pwq_cell import pwq_pkg::*; #(
  parameter int PID_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pwq_ctrl_t        ctrl,
  input  logic             is_tail,
  input  logic             occupied,
  input  logic [PID_W-1:0] key_pid,
  input  logic [PID_W-1:0] up_pid,
  input  logic             up_mark,
  input  logic             prefix_in,
  input  logic             hit_in,
  output logic [PID_W-1:0] pid_q,
  output logic             mark_q,
  output logic             prefix_out,
  output logic             hit_out
);

  logic [PID_W-1:0] pid_r, pid_nxt;
  logic             mark_r, mark_nxt;
  logic             match;
  logic             take_up;

  // compare held pid against the broadcast key
  assign match      = occupied && (pid_r == key_pid);
  assign prefix_out = prefix_in | mark_r;
  assign hit_out    = hit_in | match;
  assign take_up    = ctrl.shift_all || (ctrl.compact && prefix_out);

  // next pid: tail write, shift from above, or hold
  always_comb begin
    pid_nxt = pid_r;
    if (ctrl.load && is_tail) begin
      pid_nxt = key_pid;
    end else if (take_up) begin
      pid_nxt = up_pid;
    end
  end

  // next mark: capture on match, travel down during compaction
  always_comb begin
    mark_nxt = mark_r;
    if (ctrl.mark_en) begin
      mark_nxt = match;
    end else if (ctrl.compact && prefix_out) begin
      mark_nxt = up_mark;
    end
  end

  always_ff @(posedge clk) begin
    pid_r <= pid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign pid_q  = pid_r;
  assign mark_q = mark_r;

endmodule

[design/pid_wait_queue.sv]
// pid_wait_queue: bounded fifo of pids with membership test and remove-all,
// built as a chain of pwq_cell slots. Depends on pwq_pkg and pwq_cell.

// Each item is one operation; its result comes on the out_ ports for one
// cycle with out_valid high, and must be taken then since there is no stall.
// Enqueue, dequeue and membership test leave busy low: a new item can start
// every cycle and the registered result shows in the cycle after acceptance.
// Remove-all marks every copy in the acceptance cycle, then the cell chain
// closes one gap per cycle; busy stays high while marked cells remain and
// while the registered result is built. Slot contents are not cleared at
// reset; only the occupancy count, the marks, the state and out_valid are.

module pid_wait_queue import pwq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_COUNT   = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_mode,
  input  logic [$clog2(PID_COUNT)-1:0]          in_pid,
  output logic                                  out_valid,
  output logic [$clog2(PID_COUNT)-1:0]          out_pid,
  output logic                                  out_hit,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_removed_count,
  output logic                                  out_now_empty,
  output logic                                  out_dropped
);

  localparam int PID_W = $clog2(PID_COUNT);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  pwq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  pwq_ctrl_t        ctrl;
  logic             accept;

  logic             out_valid_r, out_valid_nxt;
  logic [PID_W-1:0] out_pid_r, out_pid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [CNT_W-1:0] out_removed_r, out_removed_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_dropped_r, out_dropped_nxt;

  logic [PID_W-1:0] cell_pid  [QUEUE_DEPTH];
  logic             cell_mark [QUEUE_DEPTH];
  logic             prefix    [QUEUE_DEPTH+1];
  logic             hitc      [QUEUE_DEPTH+1];

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // cell chain
  assign prefix[0] = 1'b0;
  assign hitc[0]   = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PID_W-1:0] up_pid;
    logic             up_mark;
    logic             is_tail;
    logic             occupied;

    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign up_pid  = '0;
      assign up_mark = 1'b0;
    end else begin : g_mid
      assign up_pid  = cell_pid[i+1];
      assign up_mark = cell_mark[i+1];
    end

    assign is_tail  = (count_r == CNT_W'(i));
    assign occupied = (CNT_W'(i) < count_r);

    pwq_cell #(
      .PID_W (PID_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .is_tail    (is_tail),
      .occupied   (occupied),
      .key_pid    (in_pid),
      .up_pid     (up_pid),
      .up_mark    (up_mark),
      .prefix_in  (prefix[i]),
      .hit_in     (hitc[i]),
      .pid_q      (cell_pid[i]),
      .mark_q     (cell_mark[i]),
      .prefix_out (prefix[i+1]),
      .hit_out    (hitc[i+1])
    );
  end

  // controller: decode item, drive cells, build result
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    removed_nxt     = removed_r;
    ctrl            = '0;
    out_valid_nxt   = 1'b0;
    out_pid_nxt     = '0;
    out_hit_nxt     = 1'b0;
    out_removed_nxt = '0;
    out_empty_nxt   = 1'b0;
    out_dropped_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_ENQUEUE: begin
              out_valid_nxt = 1'b1;
              if (count_r == FULL) begin
                out_dropped_nxt = 1'b1;
              end else begin
                ctrl.load = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_DEQUEUE: begin
              out_valid_nxt = 1'b1;
              if (count_r != '0) begin
                ctrl.shift_all = 1'b1;
                count_nxt      = count_r - 1'b1;
                out_pid_nxt    = cell_pid[0];
                out_hit_nxt    = 1'b1;
                out_empty_nxt  = (count_r == CNT_W'(1));
              end else begin
                out_empty_nxt = 1'b1;
              end
            end
            MODE_HAS: begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = hitc[QUEUE_DEPTH];
              out_empty_nxt = (count_r == '0);
            end
            MODE_REMOVE_ALL: begin
              ctrl.mark_en = 1'b1;
              removed_nxt  = '0;
              state_nxt    = S_COMPACT;
            end
            default: ;
          endcase
        end
      end
      S_COMPACT: begin
        if (prefix[QUEUE_DEPTH]) begin
          // close the gap at the lowest marked cell
          ctrl.compact = 1'b1;
          count_nxt    = count_r - 1'b1;
          removed_nxt  = removed_r + 1'b1;
        end else begin
          out_valid_nxt   = 1'b1;
          out_removed_nxt = removed_r;
          out_empty_nxt   = (count_r == '0);
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result and counter payload registers
  always_ff @(posedge clk) begin
    removed_r     <= removed_nxt;
    out_pid_r     <= out_pid_nxt;
    out_hit_r     <= out_hit_nxt;
    out_removed_r <= out_removed_nxt;
    out_empty_r   <= out_empty_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pid           = out_pid_r;
  assign out_hit           = out_hit_r;
  assign out_removed_count = out_removed_r;
  assign out_now_empty     = out_empty_r;
  assign out_dropped       = out_dropped_r;

endmodule

[sim/tb.sv]
// tb: self-checking testbench for pid_wait_queue, directed corner items then
// random bursts, checked against a queue model. Depends on pwq_pkg and the rtl.

module tb;
  import pwq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_COUNT   = 64;
  localparam int PID_W       = $clog2(PID_COUNT);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PID_W-1:0] pid_t;

  // one result item, fields in port order
  typedef struct packed {
    pid_t               pid;
    logic               hit;
    logic [COUNT_W-1:0] removed_count;
    logic               now_empty;
    logic               dropped;
  } queue_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  pid_t               in_pid;
  logic               out_valid;
  pid_t               out_pid;
  logic               out_hit;
  logic [COUNT_W-1:0] out_removed_count;
  logic               out_now_empty;
  logic               out_dropped;

  // model of the queue contents, index 0 the oldest
  pid_t          held_pids[$];
  queue_result_t pending_results[$];

  int n_accepted = 0;
  int n_retired  = 0;
  int n_errors   = 0;
  int burst_left = 0;

  pid_wait_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_COUNT   (PID_COUNT)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_pid            (in_pid),
    .out_valid         (out_valid),
    .out_pid           (out_pid),
    .out_hit           (out_hit),
    .out_removed_count (out_removed_count),
    .out_now_empty     (out_now_empty),
    .out_dropped       (out_dropped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #3000000;
    $display("tb: done, errors");
    $finish;
  end

  // first ten failures are printed, later ones only counted
  function automatic void log_failure(string msg);
    n_errors++;
    if (n_errors <= 10) $display("%s", msg);
  endfunction

  // one result as text
  function automatic string fmt_result(queue_result_t r);
    return $sformatf("pid %0d hit %0d removed %0d empty %0d dropped %0d",
                     r.pid, r.hit, r.removed_count, r.now_empty, r.dropped);
  endfunction

  // apply one operation to the queue model and return its result
  function automatic queue_result_t apply_queue_op(logic [1:0] mode, pid_t pid);
    queue_result_t r;
    pid_t          kept[$];
    r = '0;
    case (mode)
      MODE_ENQUEUE: begin
        if (held_pids.size() >= QUEUE_DEPTH) r.dropped = 1'b1;
        else held_pids.push_back(pid);
      end
      MODE_DEQUEUE: begin
        if (held_pids.size() > 0) begin
          r.pid = held_pids.pop_front();
          r.hit = 1'b1;
        end
      end
      MODE_HAS: begin
        foreach (held_pids[k]) if (held_pids[k] == pid) r.hit = 1'b1;
      end
      MODE_REMOVE_ALL: begin
        foreach (held_pids[k]) begin
          if (held_pids[k] == pid) r.removed_count++;
          else kept.push_back(held_pids[k]);
        end
        held_pids = kept;
      end
      default: ;
    endcase
    r.now_empty = (held_pids.size() == 0);
    return r;
  endfunction

  // check results against the oldest expectation, then predict the accepted item
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_pid, out_hit, out_removed_count, out_now_empty, out_dropped};
        if (pending_results.size() == 0) begin
          log_failure({"tb: result with none expected: ", fmt_result(got)});
        end else begin
          want = pending_results.pop_front();
          n_retired++;
          if (got.pid !== want.pid || got.hit !== want.hit ||
              got.removed_count !== want.removed_count ||
              got.now_empty !== want.now_empty || got.dropped !== want.dropped) begin
            log_failure({"tb: mismatch: exp ", fmt_result(want), ", got ", fmt_result(got)});
          end
        end
      end
      if (start && !busy) pending_results.push_back(apply_queue_op(in_mode, in_pid));
    end
  end

  // offer one item and hold it until the block takes it
  task automatic send_op(input logic [1:0] mode, input pid_t pid);
    start   <= 1'b1;
    in_mode <= mode;
    in_pid  <= pid;
    do @(posedge clk); while (busy);
    n_accepted++;
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop sending until every accepted item has its result
  task automatic drain_results;
    int waited;
    waited = 0;
    start <= 1'b0;
    while (n_retired != n_accepted && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // operations on an empty queue
  task automatic test_empty_queue;
    send_op(MODE_DEQUEUE, pid_t'(PID_COUNT - 1));
    send_op(MODE_HAS, '0);
    send_op(MODE_REMOVE_ALL, pid_t'(PID_COUNT - 1));
    drain_results();
  endtask

  // smallest and largest pid through every operation
  task automatic test_pid_extremes;
    send_op(MODE_ENQUEUE, '0);
    send_op(MODE_ENQUEUE, pid_t'(PID_COUNT - 1));
    send_op(MODE_HAS, pid_t'(PID_COUNT - 1));
    send_op(MODE_HAS, pid_t'(1));
    send_op(MODE_DEQUEUE, '0);
    send_op(MODE_REMOVE_ALL, pid_t'(PID_COUNT - 1));
    drain_results();
  endtask

  // fill with one pid, overflow, then remove every copy at once
  task automatic test_full_queue;
    repeat (QUEUE_DEPTH) send_op(MODE_ENQUEUE, pid_t'(42));
    send_op(MODE_ENQUEUE, pid_t'(7));
    send_op(MODE_REMOVE_ALL, pid_t'(42));
    drain_results();
  endtask

  // one random phase: operation mix and a small pid pool for repeats
  task automatic run_random_phase(input int n_ops, input int enq_pct, input int deq_pct,
                                  input int has_pct, input bit with_gaps);
    pid_t       pool[4];
    int         pick;
    logic [1:0] mode;
    pid_t       pid;
    foreach (pool[k]) pool[k] = pid_t'($urandom_range(0, PID_COUNT - 1));
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) mode = MODE_ENQUEUE;
      else if (pick < enq_pct + deq_pct) mode = MODE_DEQUEUE;
      else if (pick < enq_pct + deq_pct + has_pct) mode = MODE_HAS;
      else mode = MODE_REMOVE_ALL;
      if ($urandom_range(0, 3) == 0) pid = pid_t'($urandom_range(0, PID_COUNT - 1));
      else pid = pool[$urandom_range(0, 3)];
      send_op(mode, pid);
      if (with_gaps) pace_sender();
    end
  endtask

  // phases that fill, drain, mix and prune the queue
  task automatic test_random_traffic;
    bit with_gaps;
    for (int ph = 0; ph < 12; ph++) begin
      with_gaps = ($urandom_range(0, 3) != 0);
      case (ph % 4)
        0: run_random_phase(110, 70, 10, 10, with_gaps);
        1: run_random_phase(110, 40, 25, 20, with_gaps);
        2: run_random_phase(110, 45, 5, 10, with_gaps);
        default: run_random_phase(110, 10, 60, 15, with_gaps);
      endcase
      if (ph % 3 == 2) drain_results();
    end
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_mode = MODE_ENQUEUE;
    in_pid  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_pid_extremes();
    test_full_queue();
    test_random_traffic();

    drain_results();
    repeat (QUEUE_DEPTH + 4) @(posedge clk);
    if (pending_results.size() != 0)
      log_failure($sformatf("tb: %0d results never arrived", pending_results.size()));

    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
